[rtl/ssd_pkg.sv]
`timescale 1ns / 1ps

package ssd_pkg;

	// joint count and field widths
	localparam int JOINTS      = 2;
	localparam int VEL_W       = 24;
	localparam int RATE_W      = 21;
	localparam int NOW_W       = 32;
	localparam int RATIO_W     = 32;
	localparam int PROD_W      = RATE_W + RATIO_W;
	localparam int CFG_W       = 32;
	localparam int CFG_IDX_W   = 3;
	localparam int IN_TDATA_W  = 80;
	localparam int OUT_TDATA_W = 40;
	localparam int TOTAL_W     = 32;
	localparam int SJOINT_W    = 2;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ENABLE       = 3'd0,
		REG_RATIO_ONE    = 3'd1,
		REG_RATIO_TWO    = 3'd2,
		REG_MIN_PULSE    = 3'd3,
		REG_QUIET_VEL    = 3'd4,
		REG_MIN_EXPECTED = 3'd5,
		REG_STALL_TIME   = 3'd6
	} reg_idx_t;

	// item kinds
	typedef enum logic {
		KIND_SAMPLE = 1'b0,
		KIND_CLEAR  = 1'b1
	} kind_t;

	// configuration reset values
	localparam logic [19:0] MIN_PULSE_RST    = 20'd100;
	localparam logic [22:0] QUIET_VEL_RST    = 23'd50;
	localparam logic [23:0] MIN_EXPECTED_RST = 24'd200;
	localparam logic [15:0] STALL_TIME_RST   = 16'd500;

	typedef struct packed {
		logic                             enable;
		logic [JOINTS-1:0][RATIO_W-1:0]   ratio;
		logic [19:0]                      min_pulse_rate;
		logic [22:0]                      quiet_velocity;
		logic [23:0]                      min_expected_rate;
		logic [15:0]                      stall_time_ms;
	} cfg_t;

	// raw sample as taken from the input stream
	typedef struct packed {
		kind_t              kind;
		logic               joint;
		logic               trusted;
		logic [VEL_W-1:0]   vel;
		logic [RATE_W-1:0]  rate;
		logic [NOW_W-1:0]   now;
	} sample_t;

	// sample after magnitudes and the expected-rate product
	typedef struct packed {
		kind_t              kind;
		logic               joint;
		logic               trusted;
		logic [VEL_W-1:0]   vel_mag;
		logic [RATE_W-1:0]  rate_mag;
		logic [PROD_W-1:0]  expected;
		logic [NOW_W-1:0]   now;
	} meas_t;

endpackage

[rtl/ssd_measure.sv]
`timescale 1ns / 1ps

module ssd_measure import ssd_pkg::*; (
	input  cfg_t    cfg,
	input  sample_t in_item,
	output meas_t   out_item
);

	logic [VEL_W-1:0]  vel_mag;
	logic [RATE_W-1:0] rate_mag;
	logic [RATIO_W-1:0] ratio;

	// absolute values of the signed fields
	assign vel_mag  = in_item.vel[VEL_W-1] ? VEL_W'(~in_item.vel + 1'b1) : in_item.vel;
	assign rate_mag = in_item.rate[RATE_W-1] ? RATE_W'(~in_item.rate + 1'b1) : in_item.rate;

	// counts-per-step ratio of the addressed joint
	assign ratio = cfg.ratio[in_item.joint];

	// expected rate product and passed fields
	always_comb begin
		out_item.kind     = in_item.kind;
		out_item.joint    = in_item.joint;
		out_item.trusted  = in_item.trusted;
		out_item.vel_mag  = vel_mag;
		out_item.rate_mag = rate_mag;
		out_item.expected = PROD_W'(rate_mag) * PROD_W'(ratio);
		out_item.now      = in_item.now;
	end

endmodule

[rtl/ssd_judge.sv]
`timescale 1ns / 1ps

module ssd_judge import ssd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cfg_t                 cfg,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  meas_t                in_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 stall_latched,
	output logic [SJOINT_W-1:0]  stall_joint,
	output logic [TOTAL_W-1:0]   stall_total,
	output logic                 stop_request
);

	logic [JOINTS-1:0]             run_q, run_n;
	logic [JOINTS-1:0][NOW_W-1:0]  start_q, start_n;
	logic                          latched_q, latched_n;
	logic [SJOINT_W-1:0]           ljoint_q, ljoint_n;
	logic [TOTAL_W-1:0]            total_q, total_n;
	logic                          stop_q, stop_n;
	logic                          valid_q;
	logic                          take;
	logic                          suspect;
	logic                          judged;
	logic [NOW_W-1:0]              elapsed;
	logic [PROD_W-1:0]             vel_scaled;

	assign in_ready = !valid_q || out_ready;
	assign take     = in_valid && in_ready;

	// five times the velocity, scaled into Q16.16
	assign vel_scaled = PROD_W'({VEL_W'(0), in_item.vel_mag} * 3'd5) << 16;

	// suspicion test, proportional or unscaled
	always_comb begin
		if (cfg.ratio[in_item.joint] != '0) begin
			judged  = in_item.expected >= (PROD_W'(cfg.min_expected_rate) << 16);
			suspect = judged && (vel_scaled <= in_item.expected);
		end else begin
			judged  = in_item.rate_mag >= RATE_W'(cfg.min_pulse_rate);
			suspect = judged && (in_item.vel_mag <= VEL_W'(cfg.quiet_velocity));
		end
	end

	assign elapsed = in_item.now - start_q[in_item.joint];

	// timer and latch update
	always_comb begin
		run_n     = run_q;
		start_n   = start_q;
		latched_n = latched_q;
		ljoint_n  = ljoint_q;
		total_n   = total_q;
		stop_n    = 1'b0;
		if (in_item.kind == KIND_CLEAR) begin
			latched_n = 1'b0;
			ljoint_n  = '0;
		end else if (cfg.enable) begin
			if (!in_item.trusted || !suspect) begin
				run_n[in_item.joint] = 1'b0;
			end else if (!run_q[in_item.joint]) begin
				run_n[in_item.joint]   = 1'b1;
				start_n[in_item.joint] = in_item.now;
			end else if (elapsed > NOW_W'(cfg.stall_time_ms)) begin
				run_n[in_item.joint] = 1'b0;
				if (!latched_q) begin
					latched_n = 1'b1;
					ljoint_n  = SJOINT_W'(in_item.joint) + 1'b1;
					total_n   = total_q + 1'b1;
					stop_n    = 1'b1;
				end
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= 1'b0;
			run_q     <= '0;
			start_q   <= '0;
			latched_q <= 1'b0;
			ljoint_q  <= '0;
			total_q   <= '0;
			stop_q    <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
			if (take) begin
				run_q     <= run_n;
				start_q   <= start_n;
				latched_q <= latched_n;
				ljoint_q  <= ljoint_n;
				total_q   <= total_n;
				stop_q    <= stop_n;
			end
		end
	end

	// result fields follow the state left by the last transfer
	assign out_valid     = valid_q;
	assign stall_latched = latched_q;
	assign stall_joint   = ljoint_q;
	assign stall_total   = total_q;
	assign stop_request  = stop_q;

	a_latch_joint: assert property (@(posedge clk) disable iff (!arst_n)
		latched_q == (ljoint_q != '0))
		else $error("latch flag and latched joint disagree");

	a_stop_latched: assert property (@(posedge clk) disable iff (!arst_n)
		stop_q |-> latched_q)
		else $error("stop request without a latched stall");

	a_total_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(total_q) |-> stop_q && (total_q == $past(total_q) + 1'b1))
		else $error("stall total moved without a new stall");

endmodule

[rtl/stepper_stall_detector.sv]
`timescale 1ns / 1ps
// Stall watchdog for two stepper joints with encoders.
// Input stream: one item per transfer. tuser is the kind (sample or clear
// latch); tdata carries joint, trusted flag, signed encoder velocity, signed
// step pulse rate and a millisecond time stamp.
// Output stream: exactly one result per input item, in order: latch state,
// latched joint, stall total and a one-result stop request.
// Configuration: write enable, register index and data; written while idle.
// An item sits in the input register while the expected-rate multiply and
// the judge logic run, and its result is registered in the result register.
// Throughput is one item per cycle while results are taken; the input register
// takes a new item in the same cycle that its item moves on into the result register.
// When the receiver stalls, the result holds, the input register fills, and
// s_axis_tready falls until the result is taken.
// Reset clears the timers, latch and total and loads the default thresholds;
// the watchdog starts disabled.

module stepper_stall_detector import ssd_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// joint, reading_trusted, encoder_velocity[23:0], pulse_rate[20:0], now_ms[31:0], pad
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// kind
	input  logic                   s_axis_tuser,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// stall_latched, stall_joint[1:0], stall_total[31:0], stop_request, pad
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]       cfg_data
);

	cfg_t                cfg_q;
	logic                valid_s1;
	sample_t             item_s1;
	logic                ready_s1;
	meas_t               meas_item;
	logic                judge_ready;
	logic                stall_latched;
	logic [SJOINT_W-1:0] stall_joint;
	logic [TOTAL_W-1:0]  stall_total;
	logic                stop_request;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable            <= 1'b0;
			cfg_q.ratio             <= '0;
			cfg_q.min_pulse_rate    <= MIN_PULSE_RST;
			cfg_q.quiet_velocity    <= QUIET_VEL_RST;
			cfg_q.min_expected_rate <= MIN_EXPECTED_RST;
			cfg_q.stall_time_ms     <= STALL_TIME_RST;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_ENABLE:       cfg_q.enable            <= cfg_data[0];
				REG_RATIO_ONE:    cfg_q.ratio[0]          <= cfg_data;
				REG_RATIO_TWO:    cfg_q.ratio[1]          <= cfg_data;
				REG_MIN_PULSE:    cfg_q.min_pulse_rate    <= cfg_data[19:0];
				REG_QUIET_VEL:    cfg_q.quiet_velocity    <= cfg_data[22:0];
				REG_MIN_EXPECTED: cfg_q.min_expected_rate <= cfg_data[23:0];
				REG_STALL_TIME:   cfg_q.stall_time_ms     <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// input register
	assign ready_s1      = !valid_s1 || judge_ready;
	assign s_axis_tready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && s_axis_tvalid) begin
			item_s1.kind    <= kind_t'(s_axis_tuser);
			item_s1.joint   <= s_axis_tdata[0];
			item_s1.trusted <= s_axis_tdata[1];
			item_s1.vel     <= s_axis_tdata[25:2];
			item_s1.rate    <= s_axis_tdata[46:26];
			item_s1.now     <= s_axis_tdata[78:47];
		end
	end

	// magnitudes and expected rate
	ssd_measure u_measure (
		.cfg      (cfg_q),
		.in_item  (item_s1),
		.out_item (meas_item)
	);

	// suspicion timers, latch and result
	ssd_judge u_judge (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.in_valid      (valid_s1),
		.in_ready      (judge_ready),
		.in_item       (meas_item),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.stall_latched (stall_latched),
		.stall_joint   (stall_joint),
		.stall_total   (stall_total),
		.stop_request  (stop_request)
	);

	// result packing
	assign m_axis_tdata = {4'd0, stop_request, stall_total, stall_joint, stall_latched};

endmodule
